[rtl/skcrc_pkg.sv]
package skcrc_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] reg_idx_t;

  localparam mode_t MODE_IDLE    = 2'd0;
  localparam mode_t MODE_CONFIRM = 2'd1;
  localparam mode_t MODE_LISTEN  = 2'd2;

  localparam reg_idx_t REG_SYNC_BYTE    = 2'd0;
  localparam reg_idx_t REG_SOURCE_KEY   = 2'd1;
  localparam reg_idx_t REG_FRAME_LENGTH = 2'd2;

  localparam logic [7:0]  FRAME_LENGTH_RST = 8'd18;
  localparam logic [15:0] CRC_POLY         = 16'h8005;

  // one byte through the CRC-16 register, MSB first
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/sync_key_crc16_frame_receiver.sv]
// Sync/key framed byte receiver with CRC-16 check (poly 0x8005, init 0).
// Input stream: one received byte per transfer on in_tdata.
// Output stream: one transfer per input byte, the byte passed through and
//   tagged with its frame position; out_tlast marks the byte that ends a
//   frame, out_tuser[1] then reports a zero CRC residue over the frame.
// A frame opens on a byte equal to sync_byte, must be followed by
//   source_key, and ends on the byte that completes frame_length bytes.
// Configuration: APB-style write/read port, registers sync_byte (0x0),
//   source_key (0x4), frame_length (0x8); write only while the stream is idle.
// Path: each input byte is held in the input register, then in the result
//   register. Throughput: one byte per cycle while out_tready keeps up;
//   the CRC update is one byte-wide step between the two registers.
// Reset (rst_n low, synchronous): both stages empty, receiver idle, count
//   and CRC cleared, registers back to 0, 0 and 18.
// When the output side stalls, the result register holds; the input register
//   still takes one more byte, and in_tready drops only once both are full.
module sync_key_crc16_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] data_byte
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // [7:0] data_out, [15:8] frame_offset
  output logic        out_tlast,    // frame_end
  output logic [1:0]  out_tuser,    // [0] in_frame, [1] crc_ok
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import skcrc_pkg::*;

  logic [7:0]  sync_byte_r;
  logic [7:0]  source_key_r;
  logic [7:0]  frame_length_r;
  reg_idx_t    cfg_idx;
  logic        cfg_wr;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  cnt_r, cnt_nxt, cnt_inc;
  logic [15:0] crc_r, crc_nxt, crc_step, crc_first;

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        out_valid_r;
  logic [15:0] out_tdata_r;
  logic        out_tlast_r;
  logic [1:0]  out_tuser_r;

  logic        out_free;
  logic        advance;
  logic        res_frame, res_end, res_ok;
  logic [7:0]  res_off;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_byte_r    <= 8'd0;
      source_key_r   <= 8'd0;
      frame_length_r <= FRAME_LENGTH_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SYNC_BYTE:    sync_byte_r    <= cfg_pwdata[7:0];
        REG_SOURCE_KEY:   source_key_r   <= cfg_pwdata[7:0];
        REG_FRAME_LENGTH: frame_length_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SYNC_BYTE:    cfg_prdata = {24'd0, sync_byte_r};
      REG_SOURCE_KEY:   cfg_prdata = {24'd0, source_key_r};
      REG_FRAME_LENGTH: cfg_prdata = {24'd0, frame_length_r};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  // handshakes
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  // receiver step
  always_comb begin
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    res_frame = 1'b0;
    res_off   = 8'd0;
    res_end   = 1'b0;
    res_ok    = 1'b0;
    cnt_inc   = cnt_r + 8'd1;
    crc_step  = crc16_feed(crc_r, in_byte_r);
    crc_first = crc16_feed(16'h0000, in_byte_r);
    unique case (mode_r)
      MODE_CONFIRM: begin
        if (in_byte_r == source_key_r) begin
          crc_nxt   = crc_step;
          res_frame = 1'b1;
          res_off   = cnt_r;
          cnt_nxt   = cnt_inc;
          mode_nxt  = MODE_LISTEN;
        end else begin
          mode_nxt = MODE_IDLE;
          cnt_nxt  = 8'd0;
          crc_nxt  = 16'h0000;
        end
      end
      MODE_LISTEN: begin
        res_frame = 1'b1;
        res_off   = cnt_r;
        cnt_nxt   = cnt_inc;
        crc_nxt   = crc_step;
        if (cnt_inc >= frame_length_r || cnt_inc == 8'd0) begin
          res_end  = 1'b1;
          res_ok   = (crc_step == 16'h0000);
          mode_nxt = MODE_IDLE;
          cnt_nxt  = 8'd0;
          crc_nxt  = 16'h0000;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        if (in_byte_r == sync_byte_r) begin
          crc_nxt   = crc_first;
          cnt_nxt   = 8'd1;
          res_frame = 1'b1;
          mode_nxt  = MODE_CONFIRM;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      cnt_r  <= 8'd0;
      crc_r  <= 16'h0000;
    end else if (advance) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      crc_r  <= crc_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tdata_r <= {res_off, in_byte_r};
      out_tlast_r <= res_end;
      out_tuser_r <= {res_ok, res_frame};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

endmodule

[rtl/skcrc_checker.sv]
module skcrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic [1:0]  out_tuser
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("stalled output transfer changed");

  a_end_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0])
    else $error("frame end outside a frame");

  a_ok_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("crc_ok without frame end");

  a_offset_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[15:8] == 8'd0 && !out_tlast)
    else $error("nonzero frame tag outside a frame");

endmodule

bind sync_key_crc16_frame_receiver skcrc_checker u_skcrc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
